[rtl/pscp_pkg.sv]
// Shared constants and region codes for the closest point on segment block.
`timescale 1ns / 1ps
`default_nettype none

package pscp_pkg;

	// Default coordinate width and fraction width of the segment parameter.
	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	// Which case produced the nearest point.
	typedef enum logic [1:0] {
		REGION_INTERIOR = 2'd0,
		REGION_START    = 2'd1,
		REGION_END      = 2'd2,
		REGION_DEGEN    = 2'd3
	} region_t;

endpackage

`default_nettype wire

[rtl/pscp_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per stage, with a carried sideband.
`timescale 1ns / 1ps
`default_nettype none

module pscp_div_pipe #(
	parameter int LEN_WIDTH  = 34,
	parameter int FRAC_BITS  = 16,
	parameter int SIDE_WIDTH = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [LEN_WIDTH-1:0]  in_rem,
	input  wire logic [LEN_WIDTH-1:0]  in_len,
	input  wire logic [SIDE_WIDTH-1:0] in_side,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [FRAC_BITS:0]         out_quot,
	output logic [SIDE_WIDTH-1:0]      out_side
);

	// One integer bit plus FRAC_BITS fraction bits, one stage for each.
	localparam int STEPS = FRAC_BITS + 1;
	localparam int QW    = FRAC_BITS + 1;

	logic [STEPS:0]          en;
	logic                    valid_s [0:STEPS-1];
	logic [LEN_WIDTH-1:0]    rem_s   [0:STEPS-1];
	logic [LEN_WIDTH-1:0]    len_s   [0:STEPS-1];
	logic [QW-1:0]           quot_s  [0:STEPS-1];
	logic [SIDE_WIDTH-1:0]   side_s  [0:STEPS-1];

	// The last stage moves on when the consumer takes the transfer.
	assign en[STEPS] = out_ready;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic                  valid_src;
		logic [LEN_WIDTH:0]    trial;
		logic [LEN_WIDTH-1:0]  len_src;
		logic [QW-1:0]         quot_src;
		logic [SIDE_WIDTH-1:0] side_src;
		logic [LEN_WIDTH:0]    diff;
		logic                  q_bit;

		// The first step compares the dividend itself; later steps shift the remainder.
		if (i == 0) begin : g_first
			assign valid_src = in_valid;
			assign trial     = {1'b0, in_rem};
			assign len_src   = in_len;
			assign quot_src  = '0;
			assign side_src  = in_side;
		end else begin : g_next
			assign valid_src = valid_s[i-1];
			assign trial     = {rem_s[i-1], 1'b0};
			assign len_src   = len_s[i-1];
			assign quot_src  = quot_s[i-1];
			assign side_src  = side_s[i-1];
		end

		// Trial subtraction decides this quotient bit.
		assign diff  = trial - {1'b0, len_src};
		assign q_bit = (trial >= {1'b0, len_src});

		// A stage may load when it is empty or its content moves on.
		assign en[i] = !valid_s[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en[i]) begin
				valid_s[i] <= valid_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i]  <= q_bit ? diff[LEN_WIDTH-1:0] : trial[LEN_WIDTH-1:0];
				len_s[i]  <= len_src;
				quot_s[i] <= {quot_src[QW-2:0], q_bit};
				side_s[i] <= side_src;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_s[STEPS-1];
	assign out_quot  = quot_s[STEPS-1];
	assign out_side  = side_s[STEPS-1];

endmodule

`default_nettype wire

[rtl/point_segment_closest_point.sv]
// Top level: nearest point on a segment to a query point, fully pipelined.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   point_x/y, seg_start_x/y, seg_end_x/y
// output    out        out_valid / out_ready near_x, near_y, region
//
// One item enters per cycle while the output is not stalled; the pipeline has three
// stages for differences, products and sums, one divider stage per quotient
// bit, one stage for the interpolation products and one output register.
// The divider pipeline sets the depth. Reset clears only the valid bits.
// Each stage holds while full and blocked, so a stall loses and repeats nothing,
// and empty stages still take new transfers while the output waits.
`timescale 1ns / 1ps
`default_nettype none

module point_segment_closest_point
	import pscp_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] seg_start_x,
	input  wire logic signed [COORD_WIDTH-1:0] seg_start_y,
	input  wire logic signed [COORD_WIDTH-1:0] seg_end_x,
	input  wire logic signed [COORD_WIDTH-1:0] seg_end_y,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      near_x,
	output logic signed [COORD_WIDTH-1:0]      near_y,
	output logic [1:0]                         region
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;          // coordinate difference
	localparam int PW   = 2 * W + 2;      // one product of differences
	localparam int SW   = 2 * W + 3;      // sum of two products
	localparam int LW   = 2 * W + 2;      // squared length, unsigned
	localparam int QW   = FRAC_BITS + 1;  // segment parameter
	localparam int MW   = QW + DW + 1;    // parameter times difference
	localparam int SIDE = 2 + 2 * W + 2 * DW;

	// Stage enables: a stage loads when empty or when its content moves on.
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic div_in_ready;

	// Stage 1: differences against the segment start.
	logic                   v_s1;
	logic signed [DW-1:0]   dx_s1, dy_s1, ex_s1, ey_s1;
	logic signed [W-1:0]    ax_s1, ay_s1, bx_s1, by_s1;

	assign en_s1 = !v_s1 || en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1 <= DW'(seg_end_x) - DW'(seg_start_x);
			dy_s1 <= DW'(seg_end_y) - DW'(seg_start_y);
			ex_s1 <= DW'(point_x) - DW'(seg_start_x);
			ey_s1 <= DW'(point_y) - DW'(seg_start_y);
			ax_s1 <= seg_start_x;
			ay_s1 <= seg_start_y;
			bx_s1 <= seg_end_x;
			by_s1 <= seg_end_y;
		end
	end

	// Stage 2: the four products, operands widened before multiplying.
	logic                   v_s2;
	logic signed [PW-1:0]   dxdx_s2, dydy_s2, exdx_s2, eydy_s2;
	logic signed [DW-1:0]   dx_s2, dy_s2;
	logic signed [W-1:0]    ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [PW-1:0]   dx_w, dy_w, ex_w, ey_w;

	assign dx_w  = PW'(dx_s1);
	assign dy_w  = PW'(dy_s1);
	assign ex_w  = PW'(ex_s1);
	assign ey_w  = PW'(ey_s1);
	assign en_s2 = !v_s2 || en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dxdx_s2 <= dx_w * dx_w;
			dydy_s2 <= dy_w * dy_w;
			exdx_s2 <= ex_w * dx_w;
			eydy_s2 <= ey_w * dy_w;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			bx_s2   <= bx_s1;
			by_s2   <= by_s1;
		end
	end

	// Stage 3: squared length, dot product and the region decision.
	logic                   v_s3;
	logic [LW-1:0]          len2_s3, rem_s3;
	region_t                region_s3;
	logic signed [W-1:0]    selx_s3, sely_s3;
	logic signed [DW-1:0]   dx_s3, dy_s3;
	logic signed [SW-1:0]   len2_sum, dot_sum;
	region_t                region_nx;

	assign len2_sum = SW'(dxdx_s2) + SW'(dydy_s2);
	assign dot_sum  = SW'(exdx_s2) + SW'(eydy_s2);

	always_comb begin
		if (len2_sum == '0) begin
			region_nx = REGION_DEGEN;
		end else if (dot_sum < 0) begin
			region_nx = REGION_START;
		end else if (dot_sum > len2_sum) begin
			region_nx = REGION_END;
		end else begin
			region_nx = REGION_INTERIOR;
		end
	end

	assign en_s3 = !v_s3 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			len2_s3   <= len2_sum[LW-1:0];
			// Only interior items use the quotient; others divide zero.
			rem_s3    <= (region_nx == REGION_INTERIOR) ? dot_sum[LW-1:0] : '0;
			region_s3 <= region_nx;
			selx_s3   <= (region_nx == REGION_END) ? bx_s2 : ax_s2;
			sely_s3   <= (region_nx == REGION_END) ? by_s2 : ay_s2;
			dx_s3     <= dx_s2;
			dy_s3     <= dy_s2;
		end
	end

	// Divider stages between stage 3 and stage 4 produce t = dot * 2^FRAC_BITS / len2.
	logic                 div_out_valid;
	logic [QW-1:0]        div_quot;
	logic [SIDE-1:0]      div_side_in, div_side_out;

	assign div_side_in = {region_s3, selx_s3, sely_s3, dx_s3, dy_s3};

	pscp_div_pipe #(
		.LEN_WIDTH  (LW),
		.FRAC_BITS  (FRAC_BITS),
		.SIDE_WIDTH (SIDE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_in_ready),
		.in_rem    (rem_s3),
		.in_len    (len2_s3),
		.in_side   (div_side_in),
		.out_valid (div_out_valid),
		.out_ready (en_s4),
		.out_quot  (div_quot),
		.out_side  (div_side_out)
	);

	// Stage 4: scale each difference by the segment parameter.
	region_t                div_region;
	logic signed [W-1:0]    div_selx, div_sely;
	logic signed [DW-1:0]   div_dx, div_dy;
	logic signed [MW-1:0]   t_w, dx_m, dy_m;

	assign div_region = region_t'(div_side_out[SIDE-1 -: 2]);
	assign div_selx   = div_side_out[2*DW+2*W-1 -: W];
	assign div_sely   = div_side_out[2*DW+W-1 -: W];
	assign div_dx     = div_side_out[2*DW-1 -: DW];
	assign div_dy     = div_side_out[DW-1:0];
	assign t_w        = MW'({1'b0, div_quot});
	assign dx_m       = MW'(div_dx);
	assign dy_m       = MW'(div_dy);

	logic                   v_s4;
	logic signed [MW-1:0]   prodx_s4, prody_s4;
	region_t                region_s4;
	logic signed [W-1:0]    selx_s4, sely_s4;

	assign en_s4 = !v_s4 || en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			prodx_s4  <= t_w * dx_m;
			prody_s4  <= t_w * dy_m;
			region_s4 <= div_region;
			selx_s4   <= div_selx;
			sely_s4   <= div_sely;
		end
	end

	// Stage 5: floor shift, add the start point, and the output register.
	logic signed [MW-1:0]   shx, shy;
	logic                   v_s5;
	logic signed [W-1:0]    nearx_s5, neary_s5;
	region_t                region_s5;

	assign shx   = prodx_s4 >>> FRAC_BITS;
	assign shy   = prody_s4 >>> FRAC_BITS;
	assign en_s5 = !v_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			if (region_s4 == REGION_INTERIOR) begin
				nearx_s5 <= selx_s4 + shx[W-1:0];
				neary_s5 <= sely_s4 + shy[W-1:0];
			end else begin
				nearx_s5 <= selx_s4;
				neary_s5 <= sely_s4;
			end
			region_s5 <= region_s4;
		end
	end

	assign in_ready  = en_s1;
	assign out_valid = v_s5;
	assign near_x    = nearx_s5;
	assign near_y    = neary_s5;
	assign region    = region_s5;

	// An interior item always has its dividend within the squared length.
	a_interior_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (region_s3 == REGION_INTERIOR) |-> (rem_s3 <= len2_s3))
		else $error("interior dividend exceeds squared length");

	// A zero-length segment is always reported as degenerate.
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (len2_s3 == '0) |-> (region_s3 == REGION_DEGEN))
		else $error("zero-length segment not marked degenerate");

	// A blocked item in the product stage stays there unchanged.
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en_s4 |=> v_s4 && $stable(prodx_s4) && $stable(prody_s4))
		else $error("product stage lost or changed a blocked item");

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the closest point on segment block.
`timescale 1ns / 1ps

module tb;
	import pscp_pkg::*;

	localparam int CW        = COORD_WIDTH_DEF;
	localparam int FB        = FRAC_BITS_DEF;
	localparam int LATENCY   = FB + 6;
	localparam int RAND_ITEMS = 550;
	localparam int CYCLE_LIMIT = 40000;
	localparam int HOLD_CYCLES = 300;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		coord_t seg_start_x;
		coord_t seg_start_y;
		coord_t seg_end_x;
		coord_t seg_end_y;
	} seg_query_t;

	typedef struct packed {
		coord_t  near_x;
		coord_t  near_y;
		region_t region;
	} nearest_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	coord_t point_x;
	coord_t point_y;
	coord_t seg_start_x;
	coord_t seg_start_y;
	coord_t seg_end_x;
	coord_t seg_end_y;
	logic   out_valid;
	logic   out_ready;
	coord_t near_x;
	coord_t near_y;
	logic [1:0] region;

	seg_query_t pending_queries[$];
	nearest_t   nearest_expected[$];
	int         error_count;
	int         queries_sent;
	int         results_seen;
	int         cycle_count;
	bit         in_taken;
	bit         hold_done;
	int         hold_left;

	point_segment_closest_point DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.near_x      (near_x),
		.near_y      (near_y),
		.region      (region)
	);

	// Free-running clock, 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Nearest point on segment A-B to P, with the segment parameter in fixed point.
	function automatic nearest_t closest_point(seg_query_t q);
		longint px, py, ax, ay, bx, by, dx, dy, len2, dot, t, qx, qy;
		nearest_t r;
		px = longint'($signed(q.point_x));
		py = longint'($signed(q.point_y));
		ax = longint'($signed(q.seg_start_x));
		ay = longint'($signed(q.seg_start_y));
		bx = longint'($signed(q.seg_end_x));
		by = longint'($signed(q.seg_end_y));
		dx = bx - ax;
		dy = by - ay;
		len2 = dx * dx + dy * dy;
		dot = (px - ax) * dx + (py - ay) * dy;
		if (len2 == 0) begin
			r.near_x = q.seg_start_x;
			r.near_y = q.seg_start_y;
			r.region = REGION_DEGEN;
		end else if (dot < 0) begin
			r.near_x = q.seg_start_x;
			r.near_y = q.seg_start_y;
			r.region = REGION_START;
		end else if (dot > len2) begin
			r.near_x = q.seg_end_x;
			r.near_y = q.seg_end_y;
			r.region = REGION_END;
		end else begin
			// Both operands are nonnegative here, so truncation is the floor.
			t = (dot <<< FB) / len2;
			qx = (t * dx) >>> FB;
			qy = (t * dy) >>> FB;
			r.near_x = coord_t'(ax + qx);
			r.near_y = coord_t'(ay + qy);
			r.region = REGION_INTERIOR;
		end
		return r;
	endfunction

	task automatic add_query(input longint px, input longint py, input longint ax,
			input longint ay, input longint bx, input longint by);
		seg_query_t q;
		q.point_x     = coord_t'(px);
		q.point_y     = coord_t'(py);
		q.seg_start_x = coord_t'(ax);
		q.seg_start_y = coord_t'(ay);
		q.seg_end_x   = coord_t'(bx);
		q.seg_end_y   = coord_t'(by);
		pending_queries.push_back(q);
	endtask

	function automatic longint rand_coord();
		return longint'($signed(coord_t'($urandom)));
	endfunction

	function automatic longint small_coord();
		return longint'($urandom_range(16)) - 8;
	endfunction

	function automatic longint corner_coord();
		case ($urandom_range(3))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	// Sender: presents the next query at the falling edge once the last one transferred.
	always @(negedge clk) begin : sender
		seg_query_t nxt;
		bit no_idle;
		no_idle = (queries_sent >= 250 && queries_sent < 380);
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_queries.size() != 0 && (no_idle || $urandom_range(99) >= 7)) begin
				nxt = pending_queries.pop_front();
				point_x     <= nxt.point_x;
				point_y     <= nxt.point_y;
				seg_start_x <= nxt.seg_start_x;
				seg_start_y <= nxt.seg_start_y;
				seg_end_x   <= nxt.seg_end_x;
				seg_end_y   <= nxt.seg_end_y;
				in_valid    <= 1'b1;
				queries_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, one long hold-off to back the pipeline up to the input.
	always @(negedge clk) begin : receiver
		bit no_idle;
		no_idle = (results_seen >= 300 && results_seen < 420);
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!hold_done && results_seen >= 150) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 7);
		end
	end

	// Input transfers: predict the result from the ports as they were accepted.
	always @(posedge clk) begin : input_monitor
		seg_query_t q;
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			q.point_x     = point_x;
			q.point_y     = point_y;
			q.seg_start_x = seg_start_x;
			q.seg_start_y = seg_start_y;
			q.seg_end_x   = seg_end_x;
			q.seg_end_y   = seg_end_y;
			nearest_expected.push_back(closest_point(q));
		end
	end

	// Output transfers: compare each field with the oldest prediction.
	always @(posedge clk) begin : output_monitor
		nearest_t exp_r;
		if (out_valid && out_ready) begin
			results_seen++;
			if (nearest_expected.size() == 0) begin
				$error("unexpected result near_x %0d near_y %0d region %0d",
					near_x, near_y, region);
				error_count++;
			end else begin
				exp_r = nearest_expected.pop_front();
				if (near_x !== exp_r.near_x) begin
					$error("near_x expected %0d actual %0d", $signed(exp_r.near_x), near_x);
					error_count++;
				end
				if (near_y !== exp_r.near_y) begin
					$error("near_y expected %0d actual %0d", $signed(exp_r.near_y), near_y);
					error_count++;
				end
				if (region !== exp_r.region) begin
					$error("region expected %0d actual %0d", exp_r.region, region);
					error_count++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		longint ax, ay, bx, by, px, py;
		error_count  = 0;
		queries_sent = 0;
		results_seen = 0;
		cycle_count  = 0;
		in_taken     = 1'b0;
		hold_done    = 1'b0;
		hold_left    = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		out_ready    = 1'b0;
		point_x      = '0;
		point_y      = '0;
		seg_start_x  = '0;
		seg_start_y  = '0;
		seg_end_x    = '0;
		seg_end_y    = '0;

		// Directed cases: extremes, every region, exact end points.
		add_query(32767, 32767, 32767, 32767, 32767, 32767);
		add_query(-32768, -32768, -32768, -32768, -32768, -32768);
		add_query(-32768, 32767, 100, -200, 100, -200);
		add_query(0, 0, -32768, -32768, 32767, 32767);
		add_query(32767, -32768, -32768, -32768, 32767, 32767);
		add_query(-32768, -32768, 32767, 32767, -32768, -32768);
		add_query(32767, 32767, -32768, 32767, 32767, -32768);
		add_query(-50, 0, 0, 0, 100, 0);
		add_query(150, 30, 0, 0, 100, 0);
		add_query(0, 0, 0, 0, 100, 0);
		add_query(100, 0, 0, 0, 100, 0);
		add_query(0, 77, 0, 0, 100, 0);
		add_query(100, -77, 0, 0, 100, 0);
		add_query(33, 50, 0, 0, 100, 0);
		add_query(-7, -3, 5, 5, -5, -5);
		add_query(1, 0, 0, 0, 3, 1);
		add_query(-32768, 32767, 32767, -32768, -32768, 32767);
		add_query(32767, -32768, 32767, -32768, -32768, 32767);
		add_query(12345, -23456, -30000, 20000, 31000, -29000);
		add_query(-1, -1, 0, 0, 1, 1);
		add_query(5, 5, -1, -1, 1, 1);
		add_query(32767, 0, -32768, 0, 32767, 0);

		// Random queries, mixing full range with small and boundary geometry.
		repeat (RAND_ITEMS) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					add_query(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), rand_coord());
				end
				4, 5: begin
					add_query(small_coord(), small_coord(), small_coord(), small_coord(),
						small_coord(), small_coord());
				end
				6: begin
					ax = rand_coord();
					ay = rand_coord();
					add_query(rand_coord(), rand_coord(), ax, ay, ax, ay);
				end
				7: begin
					ax = rand_coord();
					ay = rand_coord();
					bx = rand_coord();
					by = rand_coord();
					if ($urandom_range(1) == 0)
						add_query(ax, ay, ax, ay, bx, by);
					else
						add_query(bx, by, ax, ay, bx, by);
				end
				8: begin
					ax = longint'($urandom_range(2000)) - 1000;
					ay = longint'($urandom_range(2000)) - 1000;
					bx = ax + small_coord() * 20;
					by = ay + small_coord() * 20;
					if ($urandom_range(1) == 0) begin
						px = ax + small_coord();
						py = ay + small_coord();
					end else begin
						px = bx + small_coord();
						py = by + small_coord();
					end
					add_query(px, py, ax, ay, bx, by);
				end
				default: begin
					add_query(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
						corner_coord(), corner_coord());
				end
			endcase
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: every query transferred and every prediction checked.
		while (pending_queries.size() != 0 || in_valid || nearest_expected.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		if (error_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
